### rtl/core/kbt_pkg.sv
// keyboard byte translator package: sizes, status codes, column codes
// and the request structs passed between the pipeline and its memories
// no dependencies
package kbt_pkg;

  localparam int KEYMAP_ROWS   = 96;
  localparam int KEYCODE_SPACE = 128;
  localparam int KM_COLS       = 3;
  localparam int DOWN_BITS     = 128;
  localparam int ROW_W         = (KEYMAP_ROWS > 1) ? $clog2(KEYMAP_ROWS) : 1;
  localparam int DOWN_W        = $clog2(DOWN_BITS);

  localparam logic [1:0] COL_NORMAL = 2'd0;
  localparam logic [1:0] COL_FN     = 2'd1;
  localparam logic [1:0] COL_NUM    = 2'd2;

  localparam logic [7:0] FN_KEY_RESET = 8'hff;

  typedef enum logic [2:0] {
    ST_SENT      = 3'd0,
    ST_LINE_ERR  = 3'd1,
    ST_RANGE     = 3'd2,
    ST_FN_UPDATE = 3'd3,
    ST_UNMAPPED  = 3'd4,
    ST_DUPLICATE = 3'd5,
    ST_TABLE_WR  = 3'd6
  } kbt_status_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [1:0]       col;
    logic [7:0]       value;
  } km_wr_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
  } km_rd_t;

  typedef struct packed {
    logic              en;
    logic [DOWN_W-1:0] addr;
  } kd_rd_t;

  typedef struct packed {
    logic              en;
    logic [DOWN_W-1:0] addr;
    logic              down;
  } kd_wr_t;

endpackage

### rtl/core/kbt_ifs.sv
// valid/ready channel interfaces of the keyboard byte translator
// received-byte channel, key event channel and register write channel
interface kbt_rx_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic       parity_error;
  logic       framing_error;
  logic       numlock_on;
  logic [6:0] table_row;
  logic [1:0] table_column;
  logic [7:0] table_value;

  modport source (
    output valid, op, rx_byte, parity_error, framing_error, numlock_on,
           table_row, table_column, table_value,
    input  ready
  );
  modport sink (
    input  valid, op, rx_byte, parity_error, framing_error, numlock_on,
           table_row, table_column, table_value,
    output ready
  );
endinterface

interface kbt_evt_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [6:0] key_code;
  logic       key_pressed;
  logic [2:0] status;

  modport source (
    output valid, event_valid, key_code, key_pressed, status,
    input  ready
  );
  modport sink (
    input  valid, event_valid, key_code, key_pressed, status,
    output ready
  );
endinterface

interface kbt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

### rtl/core/keyboard_byte_translator_unit.sv
// keyboard byte translator top level: three-stage pipeline around the keymap
// and key-down memories, with the output register on the event channel
// depends on kbt_pkg, kbt_ifs, kbt_keymap and kbt_keydown
//
// Takes one beat per clock on rx while evt is not stalled, returning exactly one
// beat on evt for each, in order, via the s1, s2 and evt registers. Stage zero
// issues the keymap row read (or the table write), stage one selects the key
// code from the three columns and tracks the Fn modifier while it reads the
// key-down bit, stage two decides press/release against that bit and writes
// it back; a write from stage two is forwarded to a read of the same code
// issued on the same edge. The whole pipeline holds while an evt beat waits,
// so rx.ready follows evt.ready combinationally. The key-down map is cleared
// at reset without a sweep. Keymap entries read before being written give
// undefined codes. The Fn register is written through cfg, resets to 255 and
// is to be written only while the block is idle; the block does not enforce it.
module keyboard_byte_translator_unit (
  input  logic             clk,
  input  logic             rst,
  kbt_rx_if.sink           rx,
  kbt_evt_if.source        evt,
  kbt_cfg_if.sink          cfg
);
  import kbt_pkg::*;

  logic        adv;
  logic        acc;
  logic [7:0]  fn_key_code;
  logic        fn_held;

  logic [6:0]  rx_key;
  logic        row_ok;
  logic        key_ok;
  kbt_status_t s0_status;

  logic        s1_valid;
  logic        s1_lookup;
  logic        s1_down;
  logic        s1_numlock;
  kbt_status_t s1_status;

  logic        s2_valid;
  logic        s2_check;
  logic        s2_down;
  logic [6:0]  s2_code;
  kbt_status_t s2_status;

  logic [KM_COLS-1:0][7:0] col_data;
  logic [7:0]  code;
  logic        is_fn;
  logic        unmapped;
  kbt_status_t s1_status_next;
  logic        s1_check_next;

  logic        cur_down;
  logic        dup;
  kbt_status_t s2_status_final;

  km_wr_t      km_wr;
  km_rd_t      km_rd;
  kd_rd_t      kd_rd;
  kd_wr_t      kd_wr;

  logic        evt_valid_q;
  logic        evt_event;
  logic [6:0]  evt_code;
  logic        evt_pressed;
  kbt_status_t evt_status;

  assign adv      = !evt_valid_q || evt.ready;
  assign rx.ready = adv;
  assign acc      = rx.valid && adv;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fn_key_code <= FN_KEY_RESET;
    end else if (cfg.valid && cfg.ready) begin
      fn_key_code <= cfg.data;
    end
  end

  // stage 0: decode the beat, write or read the keymap
  assign rx_key = rx.rx_byte[6:0];
  assign row_ok = {1'b0, rx.table_row} < 8'(KEYMAP_ROWS);
  assign key_ok = {1'b0, rx_key} < 8'(KEYMAP_ROWS);

  always_comb begin
    if (rx.op) begin
      s0_status = (row_ok && (rx.table_column < 2'(KM_COLS))) ? ST_TABLE_WR : ST_RANGE;
    end else if (rx.parity_error || rx.framing_error) begin
      s0_status = ST_LINE_ERR;
    end else if (!key_ok) begin
      s0_status = ST_RANGE;
    end else begin
      s0_status = ST_SENT;
    end
  end

  always_comb begin
    km_wr.en    = acc && rx.op && (s0_status == ST_TABLE_WR);
    km_wr.row   = rx.table_row[ROW_W-1:0];
    km_wr.col   = rx.table_column;
    km_wr.value = rx.table_value;
    km_rd.en    = acc && !rx.op;
    km_rd.row   = rx_key[ROW_W-1:0];
  end

  kbt_keymap u_keymap (
    .clk     (clk),
    .wr      (km_wr),
    .rd      (km_rd),
    .col_data(col_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_status  <= s0_status;
      s1_lookup  <= !rx.op && (s0_status == ST_SENT);
      s1_down    <= !rx.rx_byte[7];
      s1_numlock <= rx.numlock_on;
    end
  end

  // stage 1: pick the code from the three columns
  assign is_fn = col_data[COL_NORMAL] == fn_key_code;

  always_comb begin
    code = col_data[COL_NORMAL];
    if (s1_numlock && (col_data[COL_NUM] != 8'd0)) begin
      code = col_data[COL_NUM];
    end
    if (fn_held && (col_data[COL_FN] != 8'd0)) begin
      code = col_data[COL_FN];
    end
  end

  assign unmapped = (code == 8'd0) || code[7] || ({1'b0, code} >= 9'(KEYCODE_SPACE));

  always_comb begin
    s1_status_next = s1_status;
    s1_check_next  = 1'b0;
    if (s1_lookup) begin
      if (is_fn) begin
        s1_status_next = ST_FN_UPDATE;
      end else if (unmapped) begin
        s1_status_next = ST_UNMAPPED;
      end else begin
        s1_check_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fn_held <= 1'b0;
    end else if (adv && s1_valid && s1_lookup && is_fn) begin
      fn_held <= s1_down;
    end
  end

  always_comb begin
    kd_rd.en   = adv && s1_valid && s1_check_next;
    kd_rd.addr = code[DOWN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_status <= s1_status_next;
      s2_check  <= s1_check_next;
      s2_down   <= s1_down;
      s2_code   <= code[6:0];
    end
  end

  // stage 2: duplicate check and key-down update
  kbt_keydown u_keydown (
    .clk     (clk),
    .rst     (rst),
    .rd      (kd_rd),
    .wr      (kd_wr),
    .cur_down(cur_down)
  );

  assign dup = cur_down == s2_down;

  always_comb begin
    s2_status_final = s2_status;
    if (s2_check) begin
      s2_status_final = dup ? ST_DUPLICATE : ST_SENT;
    end
  end

  always_comb begin
    kd_wr.en   = adv && s2_valid && s2_check && !dup;
    kd_wr.addr = s2_code[DOWN_W-1:0];
    kd_wr.down = s2_down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid_q <= 1'b0;
    end else if (adv) begin
      evt_valid_q <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      evt_event   <= s2_check && !dup;
      evt_code    <= (s2_check && !dup) ? s2_code : 7'd0;
      evt_pressed <= s2_check && !dup && s2_down;
      evt_status  <= s2_status_final;
    end
  end

  assign evt.valid       = evt_valid_q;
  assign evt.event_valid = evt_event;
  assign evt.key_code    = evt_code;
  assign evt.key_pressed = evt_pressed;
  assign evt.status      = evt_status;

endmodule

### rtl/core/kbt_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module kbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/kbt_keymap.sv
// keymap store: one ram bank per column, all three read for one row at once
// depends on kbt_pkg and kbt_ram
module kbt_keymap (
  input  logic                                clk,
  input  kbt_pkg::km_wr_t                     wr,
  input  kbt_pkg::km_rd_t                     rd,
  output logic [kbt_pkg::KM_COLS-1:0][7:0]    col_data
);
  import kbt_pkg::*;

  for (genvar c = 0; c < KM_COLS; c++) begin : g_col
    kbt_ram #(
      .WIDTH(8),
      .DEPTH(KEYMAP_ROWS)
    ) u_bank (
      .clk  (clk),
      .we   (wr.en && (wr.col == 2'(c))),
      .waddr(wr.row),
      .wdata(wr.value),
      .re   (rd.en),
      .raddr(rd.row),
      .rdata(col_data[c])
    );
  end

endmodule

### rtl/core/kbt_keydown.sv
// key-down map: one-bit ram with per-entry valid flops for reset clearing,
// plus forwarding of a write landing on the same edge as a read
// depends on kbt_pkg and kbt_ram
module kbt_keydown (
  input  logic            clk,
  input  logic            rst,
  input  kbt_pkg::kd_rd_t rd,
  input  kbt_pkg::kd_wr_t wr,
  output logic            cur_down
);
  import kbt_pkg::*;

  logic [DOWN_BITS-1:0] written;
  logic [DOWN_W-1:0]    addr_q;
  logic                 fwd_hit;
  logic                 fwd_val;
  logic                 ram_q;

  kbt_ram #(
    .WIDTH(1),
    .DEPTH(DOWN_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.down),
    .re   (rd.en),
    .raddr(rd.addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        fwd_hit <= wr.en && (wr.addr == rd.addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      addr_q  <= rd.addr;
      fwd_val <= wr.down;
    end
  end

  assign cur_down = fwd_hit ? fwd_val : (written[addr_q] && ram_q);

endmodule
